/* hdl/tks_pkg.sv */
// package for the two-key record sorter: payload types, control struct, key compare
`timescale 1ns / 1ps

package tks_pkg;

	localparam int unsigned CapacityDefault = 32;

	// one stored record
	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] roll;
		logic [15:0] marks;
	} rec_t;

	// input item
	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] roll;
		logic [15:0] marks;
		logic        last;
	} in_t;

	// result item
	typedef struct packed {
		logic [15:0] out_tag;
		logic [15:0] out_roll;
		logic [15:0] out_marks;
		logic        out_last;
		logic        overflow;
	} out_t;

	// control broadcast to every cell
	typedef struct packed {
		logic ins;  // insert the new record this cycle
		logic pop;  // shift the chain toward cell 0 this cycle
	} ctl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	// true when x must stand before y: marks descending, then roll ascending
	function automatic logic goes_before(rec_t x, rec_t y);
		logic res;
		if (x.marks != y.marks) begin
			res = (x.marks > y.marks);
		end else begin
			res = (x.roll < y.roll);
		end
		return res;
	endfunction

endpackage

/* hdl/tks_cell.sv */
// one cell of the sorting chain: holds a record, inserts, shifts right on insert, left on pop
`timescale 1ns / 1ps

module tks_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  tks_pkg::ctl_t ctl,
	input  tks_pkg::rec_t new_rec,
	input  tks_pkg::rec_t left_rec,
	input  logic         left_valid,
	input  logic         left_before,
	input  tks_pkg::rec_t right_rec,
	input  logic         right_valid,
	output tks_pkg::rec_t rec,
	output logic         valid,
	output logic         ahead
);
	import tks_pkg::*;

	rec_t rec_q;
	logic valid_q;
	logic take_new;

	// new record goes ahead of the one held here
	assign ahead = valid_q && goes_before(new_rec, rec_q);

	// new record lands here when it is not pushed past and this is its slot
	assign take_new = !left_before && (ahead || (!valid_q && left_valid));

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= right_valid;
		end else if (ctl.ins && (left_before || take_new)) begin
			valid_q <= 1'b1;
		end
	end

	// record payload
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			rec_q <= right_rec;
		end else if (ctl.ins && left_before) begin
			rec_q <= left_rec;
		end else if (ctl.ins && take_new) begin
			rec_q <= new_rec;
		end
	end

	assign rec   = rec_q;
	assign valid = valid_q;

endmodule

/* hdl/two_key_record_sorter.sv */
// two-key record sorter: insertion chain of cells, then drains the sorted batch from cell 0
// a record enters the chain in the cycle of its transfer unless the chain is full, one record per cycle while loading
// the first sorted result is offered the cycle after the transfer of the record marked last
// the batch then drains one result per cycle from cell 0 while sorted_stall is low
// input is stalled while a batch drains
// reset clears all cell valid bits, the drop flag and the state, leaving an empty batch
`timescale 1ns / 1ps

module two_key_record_sorter #(
	parameter int unsigned CAPACITY = tks_pkg::CapacityDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         rec_valid,
	output logic         rec_stall,
	input  tks_pkg::in_t  rec_data,
	output logic         sorted_valid,
	input  logic         sorted_stall,
	output tks_pkg::out_t sorted_data
);
	import tks_pkg::*;

	rec_t                cell_rec   [CAPACITY];
	rec_t                left_rec   [CAPACITY];
	rec_t                right_rec  [CAPACITY];
	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_before;
	logic [CAPACITY-1:0] left_valid;
	logic [CAPACITY-1:0] left_before;
	logic [CAPACITY-1:0] right_valid;

	rec_t   new_rec;
	ctl_t   ctl;
	state_t state_q, state_d;
	logic   dropped_q;
	logic   in_xfer;
	logic   full;
	logic   final_xfer;

	assign new_rec.tag   = rec_data.tag;
	assign new_rec.roll  = rec_data.roll;
	assign new_rec.marks = rec_data.marks;

	assign full       = cell_valid[CAPACITY-1];
	assign in_xfer    = rec_valid && !rec_stall;
	assign ctl.ins    = in_xfer && !full;
	assign ctl.pop    = sorted_valid && !sorted_stall;
	assign final_xfer = ctl.pop && !cell_valid[1];

	// chain of cells with neighbor wiring
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_rec[i]    = new_rec;
			assign left_valid[i]  = 1'b1;
			assign left_before[i] = 1'b0;
		end else begin : g_body
			assign left_rec[i]    = cell_rec[i-1];
			assign left_valid[i]  = cell_valid[i-1];
			assign left_before[i] = cell_before[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_rec[i]   = cell_rec[i];
			assign right_valid[i] = 1'b0;
		end else begin : g_mid
			assign right_rec[i]   = cell_rec[i+1];
			assign right_valid[i] = cell_valid[i+1];
		end

		tks_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_rec     (new_rec),
			.left_rec    (left_rec[i]),
			.left_valid  (left_valid[i]),
			.left_before (left_before[i]),
			.right_rec   (right_rec[i]),
			.right_valid (right_valid[i]),
			.rec         (cell_rec[i]),
			.valid       (cell_valid[i]),
			.ahead       (cell_before[i])
		);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d      = state_q;
		rec_stall    = 1'b0;
		sorted_valid = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && rec_data.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				rec_stall    = 1'b1;
				sorted_valid = cell_valid[0];
				if (final_xfer) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// drop flag for the current batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q <= 1'b0;
		end else if (final_xfer) begin
			dropped_q <= 1'b0;
		end else if (in_xfer && full) begin
			dropped_q <= 1'b1;
		end
	end

	// result payload straight from the head cell
	assign sorted_data.out_tag   = cell_rec[0].tag;
	assign sorted_data.out_roll  = cell_rec[0].roll;
	assign sorted_data.out_marks = cell_rec[0].marks;
	assign sorted_data.out_last  = !cell_valid[1];
	assign sorted_data.overflow  = dropped_q;

endmodule
